>>> hdl/stpm_pkg.sv
// Package for the surface touch point mapper.
// Holds register codes, result widths, rounding constants and the result type.
// No dependencies.
package stpm_pkg;

    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CORNER_A = 2'd0,
        CFG_CORNER_B = 2'd1,
        CFG_CORNER_D = 2'd2
    } cfg_index_t;

    localparam int TOUCH_W     = 16;
    localparam int U_QW        = 16;
    localparam int U_SHIFT     = 15;
    localparam logic [TOUCH_W-1:0] U_ONE  = 16'd16384;
    localparam logic [U_QW-1:0]    U_QMAX = 16'd49152;
    localparam int V_BITS      = 15;
    localparam int VQ_W        = 32;
    localparam int RHS_SHIFT   = 30;
    localparam int QUEUE_DEPTH = 2;
    localparam int MUL_DIGIT_NARROW = 16;
    localparam int MUL_DIGIT_WIDE   = 8;

    typedef struct packed {
        logic [TOUCH_W-1:0] u;
        logic [TOUCH_W-1:0] v;
        logic               degen;
    } stpm_result_t;

endpackage

>>> hdl/stpm_front.sv
// Front end of the touch point mapper: corner registers, item accept, edge and offset vectors.
// Depends on stpm_pkg.
module stpm_front #(
    parameter int COORD_WIDTH = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                full,
    input  logic signed [COORD_WIDTH-1:0]       point_x,
    input  logic signed [COORD_WIDTH-1:0]       point_y,
    input  logic signed [COORD_WIDTH-1:0]       point_z,
    input  logic                                cfg_valid,
    input  logic [stpm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [3*COORD_WIDTH-1:0]            cfg_data,
    output logic                                push,
    output logic [9*(COORD_WIDTH+1)-1:0]        item
);
    import stpm_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = COORD_WIDTH + 1;

    logic signed [W-1:0] cor_reg [3][3];
    logic signed [W-1:0] pt [3];

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;
    assign push  = start & ~full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    cor_reg[c][k] <= '0;
                end
            end
        end
        else if (cfg_valid)
        begin
            for (int k = 0; k < 3; k++)
            begin
                case (cfg_index)
                    CFG_CORNER_A: cor_reg[0][k] <= cfg_data[k*W +: W];
                    CFG_CORNER_B: cor_reg[1][k] <= cfg_data[k*W +: W];
                    CFG_CORNER_D: cor_reg[2][k] <= cfg_data[k*W +: W];
                    default: ;
                endcase
            end
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_diff
        assign item[k*DW +: DW]     = DW'(cor_reg[1][k]) - DW'(cor_reg[0][k]);
        assign item[(3+k)*DW +: DW] = DW'(cor_reg[2][k]) - DW'(cor_reg[0][k]);
        assign item[(6+k)*DW +: DW] = DW'(pt[k]) - DW'(cor_reg[0][k]);
    end

endmodule

>>> hdl/stpm_fifo.sv
// Short item queue between the front end and the arithmetic back end.
// Depends on stpm_pkg for the queue depth.
module stpm_fifo #(
    parameter int DATA_W = 189
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output logic [DATA_W-1:0] pop_data
);
    import stpm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [DATA_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [PTR_W:0]    cnt_reg, cnt_next;

    assign full     = (cnt_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + PTR_W'(1) : wr_reg;
        rd_next  = pop  ? rd_reg + PTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/stpm_mul.sv
// Pipelined unsigned multiplier, one digit of the second operand per stage, with side data.
// Depends on stpm_pkg.
module stpm_mul #(
    parameter int LANES  = 1,
    parameter int AW     = 44,
    parameter int BW     = 44,
    parameter int DG     = 16,
    parameter int SIDE_W = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [LANES-1:0][AW-1:0]       in_a,
    input  logic [LANES-1:0][BW-1:0]       in_b,
    input  logic [SIDE_W-1:0]              in_side,
    output logic                           out_valid,
    output logic [LANES-1:0][AW+BW-1:0]    out_p,
    output logic [SIDE_W-1:0]              out_side
);
    import stpm_pkg::*;

    localparam int NST = (BW + DG - 1) / DG;
    localparam int BPW = NST * DG;
    localparam int PRW = AW + BW;
    localparam int PTW = AW + DG;

    logic                        vld_reg  [NST+1];
    logic [SIDE_W-1:0]           side_reg [NST+1];
    logic [LANES-1:0][PRW-1:0]   acc_reg  [NST+1];
    logic [LANES-1:0][AW-1:0]    a_reg    [NST];
    logic [LANES-1:0][BW-1:0]    b_reg    [NST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg[0]    <= in_a;
        b_reg[0]    <= in_b;
        acc_reg[0]  <= '0;
        side_reg[0] <= in_side;
    end

    for (genvar s = 0; s < NST; s++)
    begin : g_st
        logic [LANES-1:0][PTW-1:0] part;

        always_comb
        begin
            logic [BPW-1:0] bx;
            bx = '0;
            for (int l = 0; l < LANES; l++)
            begin
                bx      = BPW'(b_reg[s][l]);
                part[l] = PTW'(a_reg[s][l]) * PTW'(bx[s*DG +: DG]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                acc_reg[s+1][l] <= acc_reg[s][l] + (PRW'(part[l]) << (s*DG));
            end
            side_reg[s+1] <= side_reg[s];
        end

        if (s + 1 < NST)
        begin : g_opnd
            always_ff @(posedge clk)
            begin
                a_reg[s+1] <= a_reg[s];
                b_reg[s+1] <= b_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[NST];
    assign out_p     = acc_reg[NST];
    assign out_side  = side_reg[NST];

endmodule

>>> hdl/stpm_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating, with side data.
// Depends on stpm_pkg.
module stpm_div #(
    parameter int NW     = 60,
    parameter int DVW    = 45,
    parameter int QW     = 16,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NW-1:0]     in_n,
    input  logic [DVW-1:0]    in_d,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QW-1:0]     out_q,
    output logic [SIDE_W-1:0] out_side
);
    import stpm_pkg::*;

    localparam int XW = (NW > DVW + QW) ? NW : DVW + QW;

    logic              vld_reg  [QW+1];
    logic              sat_reg  [QW+1];
    logic [QW-1:0]     q_reg    [QW+1];
    logic [SIDE_W-1:0] side_reg [QW+1];
    logic [NW-1:0]     rem_reg  [QW];
    logic [DVW-1:0]    d_reg    [QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= in_n;
        d_reg[0]    <= in_d;
        sat_reg[0]  <= XW'(in_n) >= (XW'(in_d) << QW);
        q_reg[0]    <= '0;
        side_reg[0] <= in_side;
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_st
        localparam int B = QW - 1 - i;
        logic [XW-1:0] trial;
        logic          ge;

        assign trial = XW'(d_reg[i]) << B;
        assign ge    = XW'(rem_reg[i]) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            q_reg[i+1]    <= ge ? (q_reg[i] | (QW'(1) << B)) : q_reg[i];
            sat_reg[i+1]  <= sat_reg[i];
            side_reg[i+1] <= side_reg[i];
        end

        if (i + 1 < QW)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                rem_reg[i+1] <= ge ? NW'(XW'(rem_reg[i]) - trial) : rem_reg[i];
                d_reg[i+1]   <= d_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign out_q     = sat_reg[QW] ? '1 : q_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

>>> hdl/stpm_back.sv
// Back end of the touch point mapper: dot products, the u and v quotients and the root search.
// Depends on stpm_pkg, stpm_mul and stpm_div.
module stpm_back #(
    parameter int COORD_WIDTH = 20
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [9*(COORD_WIDTH+1)-1:0]   in_item,
    output logic                           out_valid,
    output stpm_pkg::stpm_result_t         out_result
);
    import stpm_pkg::*;

    localparam int DW   = COORD_WIDTH + 1;
    localparam int PW   = 2 * DW + 2;
    localparam int MW   = 2 * PW;
    localparam int SW   = MW + 1;
    localparam int SQW  = 2 * SW;
    localparam int NLW  = MW + PW;
    localparam int DENW = MW + 2 * PW;
    localparam int RHW  = SQW + RHS_SHIFT;
    localparam int UNW  = PW + U_QW;

    typedef struct packed {
        logic [PW-1:0] lab2;
        logic [PW-1:0] lad2;
        logic [PW-1:0] abad;
        logic [PW-1:0] rab;
        logic [PW-1:0] adr;
        logic          degen;
    } su_t;

    typedef struct packed {
        logic               sx;
        logic               sy;
        logic [TOUCH_W-1:0] u;
        logic               degen;
        logic [PW-1:0]      lab2;
        logic [PW-1:0]      lad2;
    } s1_t;

    typedef struct packed {
        logic [MW-1:0]      nn;
        logic [PW-1:0]      lab2;
        logic [PW-1:0]      lad2;
        logic [TOUCH_W-1:0] u;
        logic               degen;
        logic               nz;
    } s2_t;

    typedef struct packed {
        logic [SQW-1:0]     sq;
        logic [PW-1:0]      lad2;
        logic [TOUCH_W-1:0] u;
        logic               degen;
        logic               nz;
    } s3_t;

    typedef struct packed {
        logic [SQW-1:0]     sq;
        logic [TOUCH_W-1:0] u;
        logic               degen;
        logic               nz;
    } s4_t;

    typedef struct packed {
        logic [TOUCH_W-1:0] u;
        logic               degen;
        logic               nz;
    } s5_t;

    logic signed [DW-1:0] ab [3];
    logic signed [DW-1:0] ad [3];
    logic signed [DW-1:0] rr [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_unpack
        assign ab[k] = in_item[k*DW +: DW];
        assign ad[k] = in_item[(3+k)*DW +: DW];
        assign rr[k] = in_item[(6+k)*DW +: DW];
    end

    logic                   v1_reg, v2_reg;
    logic signed [2*DW-1:0] pr_reg  [5][3];
    logic signed [PW-1:0]   sum_reg [5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            pr_reg[0][k] <= (2*DW)'(ab[k]) * (2*DW)'(ab[k]);
            pr_reg[1][k] <= (2*DW)'(ad[k]) * (2*DW)'(ad[k]);
            pr_reg[2][k] <= (2*DW)'(ab[k]) * (2*DW)'(ad[k]);
            pr_reg[3][k] <= (2*DW)'(rr[k]) * (2*DW)'(ab[k]);
            pr_reg[4][k] <= (2*DW)'(rr[k]) * (2*DW)'(ad[k]);
        end
        for (int i = 0; i < 5; i++)
        begin
            sum_reg[i] <= PW'(pr_reg[i][0]) + PW'(pr_reg[i][1]) + PW'(pr_reg[i][2]);
        end
    end

    // Quotient for u.
    su_t            du_side_in, du_side_out;
    logic [PW-1:0]  rab_mag;
    logic [UNW-1:0] du_n;
    logic [PW:0]    du_d;
    logic           du_valid;
    logic [U_QW-1:0] du_q;

    always_comb
    begin
        du_side_in.lab2  = sum_reg[0];
        du_side_in.lad2  = sum_reg[1];
        du_side_in.abad  = sum_reg[2];
        du_side_in.rab   = sum_reg[3];
        du_side_in.adr   = sum_reg[4];
        du_side_in.degen = (sum_reg[0] == '0) || (sum_reg[1] == '0);
        rab_mag = sum_reg[3][PW-1] ? PW'(-sum_reg[3]) : PW'(sum_reg[3]);
        du_n    = (UNW'(rab_mag) << U_SHIFT) + UNW'($unsigned(sum_reg[0]));
        du_d    = {sum_reg[0], 1'b0};
    end

    stpm_div #(
        .NW     (UNW),
        .DVW    (PW + 1),
        .QW     (U_QW),
        .SIDE_W ($bits(su_t))
    ) u_div_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_n      (du_n),
        .in_d      (du_d),
        .in_side   (du_side_in),
        .out_valid (du_valid),
        .out_q     (du_q),
        .out_side  (du_side_out)
    );

    // Products of the dot products: lab2*lad2, abad^2, lab2*adr, rab*abad.
    logic [3:0][PW-1:0] m1_a, m1_b;
    logic [3:0][MW-1:0] m1_p;
    s1_t                m1_side_in, m1_side_out;
    logic               m1_valid;
    logic [PW-1:0]      abad_mag, adr_mag, rabm;
    logic [U_QW-1:0]    qu;

    always_comb
    begin
        abad_mag = du_side_out.abad[PW-1] ? PW'(-du_side_out.abad) : du_side_out.abad;
        adr_mag  = du_side_out.adr[PW-1]  ? PW'(-du_side_out.adr)  : du_side_out.adr;
        rabm     = du_side_out.rab[PW-1]  ? PW'(-du_side_out.rab)  : du_side_out.rab;
        qu       = (du_q > U_QMAX) ? U_QMAX : du_q;
        m1_a[0]  = du_side_out.lab2;
        m1_b[0]  = du_side_out.lad2;
        m1_a[1]  = abad_mag;
        m1_b[1]  = abad_mag;
        m1_a[2]  = du_side_out.lab2;
        m1_b[2]  = adr_mag;
        m1_a[3]  = rabm;
        m1_b[3]  = abad_mag;
        m1_side_in.sx    = du_side_out.adr[PW-1];
        m1_side_in.sy    = du_side_out.rab[PW-1] ^ du_side_out.abad[PW-1];
        m1_side_in.u     = U_ONE - TOUCH_W'(qu);
        m1_side_in.degen = du_side_out.degen;
        m1_side_in.lab2  = du_side_out.lab2;
        m1_side_in.lad2  = du_side_out.lad2;
    end

    stpm_mul #(
        .LANES  (4),
        .AW     (PW),
        .BW     (PW),
        .DG     (MUL_DIGIT_NARROW),
        .SIDE_W ($bits(s1_t))
    ) u_mul_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (du_valid),
        .in_a      (m1_a),
        .in_b      (m1_b),
        .in_side   (m1_side_in),
        .out_valid (m1_valid),
        .out_p     (m1_p),
        .out_side  (m1_side_out)
    );

    // The squared normal length and the triple product magnitude.
    logic [0:0][SW-1:0]  m2_a;
    logic [0:0][SQW-1:0] m2_p;
    s2_t                 m2_side_in, m2_side_out;
    logic                m2_valid;

    always_comb
    begin
        if (m1_side_out.sx == m1_side_out.sy)
        begin
            m2_a[0] = (m1_p[2] >= m1_p[3]) ? SW'(m1_p[2] - m1_p[3]) : SW'(m1_p[3] - m1_p[2]);
        end
        else
        begin
            m2_a[0] = SW'(m1_p[2]) + SW'(m1_p[3]);
        end
        m2_side_in.nn    = m1_p[0] - m1_p[1];
        m2_side_in.nz    = (m1_p[0] != m1_p[1]);
        m2_side_in.lab2  = m1_side_out.lab2;
        m2_side_in.lad2  = m1_side_out.lad2;
        m2_side_in.u     = m1_side_out.u;
        m2_side_in.degen = m1_side_out.degen;
    end

    stpm_mul #(
        .LANES  (1),
        .AW     (SW),
        .BW     (SW),
        .DG     (MUL_DIGIT_WIDE),
        .SIDE_W ($bits(s2_t))
    ) u_mul_sq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m1_valid),
        .in_a      (m2_a),
        .in_b      (m2_a),
        .in_side   (m2_side_in),
        .out_valid (m2_valid),
        .out_p     (m2_p),
        .out_side  (m2_side_out)
    );

    logic [0:0][PW-1:0]  m3_a;
    logic [0:0][MW-1:0]  m3_b;
    logic [0:0][NLW-1:0] m3_p;
    s3_t                 m3_side_in, m3_side_out;
    logic                m3_valid;

    always_comb
    begin
        m3_a[0]          = m2_side_out.lab2;
        m3_b[0]          = m2_side_out.nn;
        m3_side_in.sq    = m2_p[0];
        m3_side_in.lad2  = m2_side_out.lad2;
        m3_side_in.u     = m2_side_out.u;
        m3_side_in.degen = m2_side_out.degen;
        m3_side_in.nz    = m2_side_out.nz;
    end

    stpm_mul #(
        .LANES  (1),
        .AW     (PW),
        .BW     (MW),
        .DG     (MUL_DIGIT_NARROW),
        .SIDE_W ($bits(s3_t))
    ) u_mul_nl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m2_valid),
        .in_a      (m3_a),
        .in_b      (m3_b),
        .in_side   (m3_side_in),
        .out_valid (m3_valid),
        .out_p     (m3_p),
        .out_side  (m3_side_out)
    );

    logic [0:0][PW-1:0]   m4_a;
    logic [0:0][DENW-1:0] m4_p;
    s4_t                  m4_side_in, m4_side_out;
    logic                 m4_valid;

    always_comb
    begin
        m4_a[0]          = m3_side_out.lad2;
        m4_side_in.sq    = m3_side_out.sq;
        m4_side_in.u     = m3_side_out.u;
        m4_side_in.degen = m3_side_out.degen;
        m4_side_in.nz    = m3_side_out.nz;
    end

    stpm_mul #(
        .LANES  (1),
        .AW     (PW),
        .BW     (NLW),
        .DG     (MUL_DIGIT_NARROW),
        .SIDE_W ($bits(s4_t))
    ) u_mul_den (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m3_valid),
        .in_a      (m4_a),
        .in_b      (m3_p),
        .in_side   (m4_side_in),
        .out_valid (m4_valid),
        .out_p     (m4_p),
        .out_side  (m4_side_out)
    );

    // Quotient of the squared height term over the denominator, saturated.
    logic [RHW-1:0]  dv_n;
    s5_t             dv_side_in, dv_side_out;
    logic            dv_valid;
    logic [VQ_W-1:0] dv_q;

    always_comb
    begin
        dv_n             = RHW'(m4_side_out.sq) << RHS_SHIFT;
        dv_side_in.u     = m4_side_out.u;
        dv_side_in.degen = m4_side_out.degen;
        dv_side_in.nz    = m4_side_out.nz;
    end

    stpm_div #(
        .NW     (RHW),
        .DVW    (DENW),
        .QW     (VQ_W),
        .SIDE_W ($bits(s5_t))
    ) u_div_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m4_valid),
        .in_n      (dv_n),
        .in_d      (m4_p[0]),
        .in_side   (dv_side_in),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_side  (dv_side_out)
    );

    // Bit search for the largest v with (2v-1)^2 not above the quotient.
    logic              rvld_reg [V_BITS+1];
    logic [VQ_W-1:0]   rq_reg   [V_BITS+1];
    logic [V_BITS-1:0] rv_reg   [V_BITS+1];
    s5_t               rs_reg   [V_BITS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvld_reg[0] <= 1'b0;
        end
        else
        begin
            rvld_reg[0] <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rq_reg[0] <= dv_q;
        rv_reg[0] <= '0;
        rs_reg[0] <= dv_side_out;
    end

    for (genvar i = 0; i < V_BITS; i++)
    begin : g_root
        localparam int K = V_BITS - 1 - i;
        logic [V_BITS-1:0] cand;
        logic [V_BITS:0]   odd;
        logic [VQ_W-1:0]   osq;

        assign cand = rv_reg[i] | (V_BITS'(1) << K);
        assign odd  = {cand, 1'b0} - (V_BITS+1)'(1);
        assign osq  = VQ_W'(odd) * VQ_W'(odd);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rvld_reg[i+1] <= 1'b0;
            end
            else
            begin
                rvld_reg[i+1] <= rvld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            rq_reg[i+1] <= rq_reg[i];
            rv_reg[i+1] <= (osq <= rq_reg[i]) ? cand : rv_reg[i];
            rs_reg[i+1] <= rs_reg[i];
        end
    end

    logic         done_reg;
    stpm_result_t res_reg, res_next;
    s5_t          fin;

    always_comb
    begin
        fin = rs_reg[V_BITS];
        if (fin.degen)
        begin
            res_next.u     = '0;
            res_next.v     = '0;
            res_next.degen = 1'b1;
        end
        else
        begin
            res_next.u     = fin.u;
            res_next.v     = fin.nz ? TOUCH_W'(rv_reg[V_BITS]) : '0;
            res_next.degen = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= rvld_reg[V_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid  = done_reg;
    assign out_result = res_reg;

endmodule

>>> hdl/surface_touch_point_mapper_core.sv
// Top level of the surface touch point mapper.
// Depends on stpm_pkg, stpm_front, stpm_fifo and stpm_back.
//
// Usage: write corners A, B and D through the configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data; cfg_ready is always high) while no item is in
// flight. A touch point is taken at a rising edge with start high and busy low.
// Each item gives one result, shown for a single cycle with done high on
// touch_u, touch_v and degenerate.
// The datapath is one pipeline and an item is taken every cycle. The latency is set
// by the chain of stages: the 16 bit divider for u, the digit serial multipliers
// for the normal and the denominator, the 32 bit divider for v and the 15 step root
// search.
// The latency grows with COORD_WIDTH through the multiplier digit counts.
// The receiver cannot stall; results leave on their own schedule. The back end
// takes an item from the queue every cycle that it holds one, so the queue never fills
// and busy stays low.
// Reset clears the corner registers to zero and empties the pipeline.
module surface_touch_point_mapper_core #(
    parameter int COORD_WIDTH = 20
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [COORD_WIDTH-1:0]      point_x,
    input  logic signed [COORD_WIDTH-1:0]      point_y,
    input  logic signed [COORD_WIDTH-1:0]      point_z,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [stpm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [3*COORD_WIDTH-1:0]           cfg_data,
    output logic                               done,
    output logic signed [stpm_pkg::TOUCH_W-1:0] touch_u,
    output logic signed [stpm_pkg::TOUCH_W-1:0] touch_v,
    output logic                               degenerate
);
    import stpm_pkg::*;

    localparam int ITEM_W = 9 * (COORD_WIDTH + 1);

    logic              push, full, empty;
    logic [ITEM_W-1:0] push_item, pop_item;
    stpm_result_t      result;

    assign cfg_ready = 1'b1;
    assign busy      = full;

    stpm_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .full      (full),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (push_item)
    );

    stpm_fifo #(
        .DATA_W (ITEM_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_item),
        .pop       (~empty),
        .full      (full),
        .empty     (empty),
        .pop_data  (pop_item)
    );

    stpm_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (~empty),
        .in_item    (pop_item),
        .out_valid  (done),
        .out_result (result)
    );

    assign touch_u    = result.u;
    assign touch_v    = result.v;
    assign degenerate = result.degen;

endmodule

>>> bench/surface_touch_point_mapper_core_tb.sv
// Testbench for surface_touch_point_mapper_core: drives touch points under several
// corner settings and checks every result against a bit-exact predictor.
// Depends on stpm_pkg and the core RTL.
`timescale 1ns / 1ps

import stpm_pkg::*;

class touch_scoreboard;
    localparam int CW = 20;

    logic [3*CW-1:0] corner_a;
    logic [3*CW-1:0] corner_b;
    logic [3*CW-1:0] corner_d;
    stpm_result_t    pending_touches[$];
    int              mismatches;
    int              checked;
    int              degenerate_seen;

    function new();
        corner_a = '0;
        corner_b = '0;
        corner_d = '0;
        mismatches = 0;
        checked = 0;
        degenerate_seen = 0;
    endfunction

    function void set_corner(cfg_index_t idx, logic [3*CW-1:0] data);
        case (idx)
            CFG_CORNER_A: corner_a = data;
            CFG_CORNER_B: corner_b = data;
            CFG_CORNER_D: corner_d = data;
            default: ;
        endcase
    endfunction

    function automatic longint sx(logic [CW-1:0] raw);
        return longint'($signed(raw));
    endfunction

    function automatic stpm_result_t project_point(logic [CW-1:0] px, logic [CW-1:0] py,
                                                   logic [CW-1:0] pz);
        longint a[3], b[3], d[3], p[3], ab[3], ad[3], r[3], n[3], c[3];
        longint lab2, lad2, rab;
        logic [63:0] t, q;
        logic signed [127:0] nn, s, ns, cs;
        logic [255:0] rhs, den, lhs, odd;
        logic [15:0] v, cand;
        stpm_result_t e;
        p[0] = sx(px);
        p[1] = sx(py);
        p[2] = sx(pz);
        for (int k = 0; k < 3; k++)
        begin
            a[k] = sx(corner_a[k*CW +: CW]);
            b[k] = sx(corner_b[k*CW +: CW]);
            d[k] = sx(corner_d[k*CW +: CW]);
            ab[k] = b[k] - a[k];
            ad[k] = d[k] - a[k];
            r[k] = p[k] - a[k];
        end
        lab2 = ab[0]*ab[0] + ab[1]*ab[1] + ab[2]*ab[2];
        lad2 = ad[0]*ad[0] + ad[1]*ad[1] + ad[2]*ad[2];
        e = '0;
        if (lab2 == 0 || lad2 == 0)
        begin
            e.degen = 1'b1;
            return e;
        end
        rab = r[0]*ab[0] + r[1]*ab[1] + r[2]*ab[2];
        t = (rab < 0) ? 64'(-rab) : 64'(rab);
        q = ((t << 15) + 64'(lab2)) / (64'(lab2) << 1);
        if (q > 64'(U_QMAX))
            q = 64'(U_QMAX);
        e.u = 16'(longint'(U_ONE) - longint'(q));

        n[0] = ab[1]*ad[2] - ab[2]*ad[1];
        n[1] = ab[2]*ad[0] - ab[0]*ad[2];
        n[2] = ab[0]*ad[1] - ab[1]*ad[0];
        c[0] = ab[1]*r[2] - ab[2]*r[1];
        c[1] = ab[2]*r[0] - ab[0]*r[2];
        c[2] = ab[0]*r[1] - ab[1]*r[0];
        v = '0;
        if (n[0] != 0 || n[1] != 0 || n[2] != 0)
        begin
            nn = '0;
            s = '0;
            for (int k = 0; k < 3; k++)
            begin
                ns = n[k];
                cs = c[k];
                nn = nn + ns*ns;
                s = s + ns*cs;
            end
            if (s < 0)
                s = -s;
            rhs = {128'b0, s};
            rhs = (rhs * rhs) << RHS_SHIFT;
            den = {128'b0, nn};
            den = den * 256'(lab2) * 256'(lad2);
            for (int k = V_BITS - 1; k >= 0; k--)
            begin
                cand = v | (16'd1 << k);
                odd = 256'(2*cand - 1);
                lhs = odd * odd * den;
                if (lhs <= rhs)
                    v = cand;
            end
        end
        e.v = v;
        return e;
    endfunction

    function void note_point(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz);
        pending_touches.insert(pending_touches.size(), project_point(px, py, pz));
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch on %s: got %0h, expected %0h (result %0d)", what, got, want,
                 checked);
        mismatches++;
    endtask

    task check_touch(logic [15:0] u, logic [15:0] v, logic degen);
        stpm_result_t e;
        if (pending_touches.size() == 0)
        begin
            report("unexpected result", {u[14:0], degen}, 16'h0);
            return;
        end
        e = pending_touches.pop_front();
        if (u !== e.u)
            report("touch_u", u, e.u);
        if (v !== e.v)
            report("touch_v", v, e.v);
        if (degen !== e.degen)
            report("degenerate", 16'(degen), 16'(e.degen));
        if (e.degen)
            degenerate_seen++;
        checked++;
    endtask
endclass

module surface_touch_point_mapper_core_tb;
    localparam int CW = 20;
    localparam int LIMIT = 600000;
    localparam int RANDOM_ITEMS = 1450;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [3*CW-1:0] cfg_data;
    logic done;
    logic signed [TOUCH_W-1:0] touch_u;
    logic signed [TOUCH_W-1:0] touch_v;
    logic degenerate;

    touch_scoreboard sb;
    int cycles;
    int points_sent;
    int settings_used;
    bit no_gaps;
    longint ca[3], cb[3], cd[3];

    surface_touch_point_mapper_core #(.COORD_WIDTH(CW)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .touch_u(touch_u), .touch_v(touch_v),
        .degenerate(degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        sb = new();
    end

    always @(posedge clk)
    begin
        if (start && !busy && rst_n)
            sb.note_point(point_x, point_y, point_z);
        if (done && rst_n)
            sb.check_touch(touch_u, touch_v, degenerate);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task send_point(longint x, longint y, longint z);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        point_x <= CW'(x);
        point_y <= CW'(y);
        point_z <= CW'(z);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        points_sent++;
    endtask

    task drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_touches.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [3*CW-1:0] pack(longint c[3]);
        return {CW'(c[2]), CW'(c[1]), CW'(c[0])};
    endfunction

    task write_corner(cfg_index_t idx, logic [3*CW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_corner(idx, data);
    endtask

    task load_corners();
        drain();
        write_corner(CFG_CORNER_A, pack(ca));
        write_corner(CFG_CORNER_B, pack(cb));
        write_corner(CFG_CORNER_D, pack(cd));
        @(posedge clk);
        settings_used++;
    endtask

    task directed_points();
        longint mx, mn;
        mx = 524287;
        mn = -524288;
        send_point(0, 0, 0);
        send_point(mx, mx, mx);
        send_point(mn, mn, mn);
        send_point(mx, mn, mx);
        send_point(mn, mx, mn);
        send_point(ca[0], ca[1], ca[2]);
        send_point(cb[0], cb[1], cb[2]);
        send_point(cd[0], cd[1], cd[2]);
        send_point((ca[0] + cb[0]) / 2, (ca[1] + cb[1]) / 2, (ca[2] + cb[2]) / 2);
    endtask

    // Mostly points on or near the surface, with some anywhere in the field range.
    task random_points(int count);
        longint sa, ta, x, y, z;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_point(longint'($signed(CW'($urandom))), longint'($signed(CW'($urandom))),
                           longint'($signed(CW'($urandom))));
            else
            begin
                sa = $urandom_range(0, 1200);
                ta = $urandom_range(0, 1200);
                x = ca[0] + ((cb[0] - ca[0]) * sa + (cd[0] - ca[0]) * ta) / 1000;
                y = ca[1] + ((cb[1] - ca[1]) * sa + (cd[1] - ca[1]) * ta) / 1000;
                z = ca[2] + ((cb[2] - ca[2]) * sa + (cd[2] - ca[2]) * ta) / 1000;
                x += longint'($urandom_range(0, 64)) - 32;
                y += longint'($urandom_range(0, 64)) - 32;
                z += longint'($urandom_range(0, 64)) - 32;
                send_point(x, y, z);
            end
        end
    endtask

    task pick_corners(int kind);
        for (int k = 0; k < 3; k++)
        begin
            case (kind)
                0: begin ca[k] = 0; cb[k] = (k == 0) ? 16000 : 0; cd[k] = (k == 1) ? 9000 : 0; end
                1: begin ca[k] = -524288; cb[k] = 524287; cd[k] = (k == 1) ? -524288 : 524287; end
                2: begin ca[k] = 0; cb[k] = 100 * (k + 1); cd[k] = 200 * (k + 1); end
                3: begin ca[k] = 1234 * k - 700; cb[k] = 5000 + k; cd[k] = ca[k]; end
                4: begin ca[k] = 10; cb[k] = (k == 0) ? 11 : 10; cd[k] = (k == 0) ? 10 : 11; end
                5: begin ca[k] = 500; cb[k] = ca[k]; cd[k] = -900 * k; end
                default:
                begin
                    ca[k] = longint'($urandom_range(0, 200000)) - 100000;
                    cb[k] = ca[k] + longint'($urandom_range(0, 400000)) - 200000;
                    cd[k] = ca[k] + longint'($urandom_range(0, 400000)) - 200000;
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycles = 0;
        points_sent = 0;
        settings_used = 0;
        no_gaps = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            ca[k] = 0;
            cb[k] = 0;
            cd[k] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_points();
        for (int phase = 0; phase < 12; phase++)
        begin
            pick_corners(phase);
            load_corners();
            directed_points();
            no_gaps = (phase % 3 == 1);
            random_points(RANDOM_ITEMS / 24);
            no_gaps = 1'b0;
            drain();
            random_points(RANDOM_ITEMS / 24);
        end

        drain();
        repeat (200) @(posedge clk);
        $display("Sent %0d touch points over %0d corner settings; %0d results checked, %0d degenerate.",
                 points_sent, settings_used, sb.checked, sb.degenerate_seen);
        if (sb.mismatches == 0 && sb.pending_touches.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> filelist.f
hdl/stpm_pkg.sv
hdl/stpm_front.sv
hdl/stpm_fifo.sv
hdl/stpm_mul.sv
hdl/stpm_div.sv
hdl/stpm_back.sv
hdl/surface_touch_point_mapper_core.sv
bench/surface_touch_point_mapper_core_tb.sv
